// ===== sv/dtad_pkg.sv =====
// Shared types, constants and codes for the dual-track alarm debouncer.
// No dependencies; imported by dtad_core and dual_track_alarm_debouncer.
`timescale 1ns / 1ps
`default_nettype none

package dtad_pkg;

    // Window length in frames and saturation cap of the run counters
    localparam int WINDOW_LEN = 100;
    localparam int COUNT_CAP  = 1023;

    localparam int RUN_W  = $clog2(COUNT_CAP + 1);   // run counter width
    localparam int WCNT_W = $clog2(WINDOW_LEN + 1);  // window count width

    // Register widths
    localparam int RUN_CFG_W = 10;
    localparam int WIN_CFG_W = 7;
    localparam int CFG_IDX_W = 2;

    // Result count field
    localparam int EVT_W = 10;
    localparam logic [EVT_W-1:0] EVENT_COUNT_MAX = 10'd1023;

    // Reset values of the registers
    localparam logic [RUN_CFG_W-1:0] RUN_ALARM_RST   = 10'd30;
    localparam logic [RUN_CFG_W-1:0] RUN_RELEASE_RST = 10'd60;
    localparam logic [WIN_CFG_W-1:0] WINDOW_CNT_RST  = 7'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ALARM    = 2'd0,
        CFG_RUN_RELEASE  = 2'd1,
        CFG_WINDOW_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_RUN    = 2'd1,
        SRC_WINDOW = 2'd2
    } t_source;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'b01,
        ST_ALARMED = 2'b10
    } t_state;

    typedef struct packed {
        logic [RUN_CFG_W-1:0] run_alarm;
        logic [RUN_CFG_W-1:0] run_release;
        logic [WIN_CFG_W-1:0] window_count;
    } t_cfg;

    typedef struct packed {
        logic [EVT_W-1:0] count;
        t_source          source;
        logic             alarm_active;
        logic             changed;
    } t_result;

    // Clip a count to the width of the result field
    function automatic logic [EVT_W-1:0] clip_count(input logic [31:0] value);
        logic [EVT_W-1:0] res;
        if (value > 32'(EVENT_COUNT_MAX)) begin
            res = EVENT_COUNT_MAX;
        end else begin
            res = value[EVT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dtad_core.sv =====
// Debounce state: run counters, sliding window shift line and alarm state.
// Depends on dtad_pkg. Advances by one frame when i_step is high.
`timescale 1ns / 1ps
`default_nettype none

module dtad_core
    import dtad_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    i_anomaly,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    t_state              r_state,  n_state;
    logic [RUN_W-1:0]    r_arun,   n_arun;
    logic [RUN_W-1:0]    r_nrun,   n_nrun;
    logic [WINDOW_LEN-1:0] r_win,  n_win;
    logic [WCNT_W-1:0]   r_wcnt,   n_wcnt;

    logic [WCNT_W-1:0]   wcnt_aged;
    logic [RUN_W-1:0]    arun_inc;
    logic [RUN_W-1:0]    nrun_inc;
    logic                run_fire;
    logic                win_fire;
    logic                release_hit;
    t_result             res;

    always_comb begin
        // Window: oldest frame drops out of the far end, newest enters at bit 0
        wcnt_aged = (r_win[WINDOW_LEN-1] && (r_wcnt != '0)) ? r_wcnt - 1'b1 : r_wcnt;
        n_win     = {r_win[WINDOW_LEN-2:0], i_anomaly};
        n_wcnt    = wcnt_aged + WCNT_W'(i_anomaly);

        arun_inc = (r_arun < RUN_W'(COUNT_CAP)) ? r_arun + 1'b1 : r_arun;
        nrun_inc = (r_nrun < RUN_W'(COUNT_CAP)) ? r_nrun + 1'b1 : r_nrun;

        n_state = r_state;
        n_arun  = r_arun;
        n_nrun  = r_nrun;

        res.changed      = 1'b0;
        res.alarm_active = 1'b0;
        res.source       = SRC_NONE;
        res.count        = '0;

        run_fire    = 1'b0;
        win_fire    = 1'b0;
        release_hit = 1'b0;

        unique case (r_state)
            ST_NORMAL: begin
                n_arun   = i_anomaly ? arun_inc : '0;
                run_fire = 32'(n_arun) >= 32'(i_cfg.run_alarm);
                win_fire = 32'(n_wcnt) >= 32'(i_cfg.window_count);
                // run track wins when both fire
                priority if (run_fire) begin
                    res.source = SRC_RUN;
                    res.count  = clip_count(32'(n_arun));
                end else if (win_fire) begin
                    res.source = SRC_WINDOW;
                    res.count  = clip_count(32'(n_wcnt));
                end
                if (run_fire || win_fire) begin
                    res.changed = 1'b1;
                    n_state     = ST_ALARMED;
                    n_arun      = '0;
                    n_nrun      = '0;
                end
            end
            ST_ALARMED: begin
                n_nrun      = i_anomaly ? '0 : nrun_inc;
                release_hit = 32'(n_nrun) >= 32'(i_cfg.run_release);
                if (release_hit) begin
                    res.changed = 1'b1;
                    res.count   = clip_count(32'(n_nrun));
                    n_state     = ST_NORMAL;
                    n_nrun      = '0;
                    n_win       = '0;
                    n_wcnt      = '0;
                end
            end
            default: begin
                n_state = ST_NORMAL;
            end
        endcase

        res.alarm_active = (n_state == ST_ALARMED);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORMAL;
            r_arun  <= '0;
            r_nrun  <= '0;
            r_win   <= '0;
            r_wcnt  <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_arun  <= n_arun;
            r_nrun  <= n_nrun;
            r_win   <= n_win;
            r_wcnt  <= n_wcnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dual_track_alarm_debouncer.sv =====
// Top level of the dual-track alarm debouncer: stream ports, register file
// and result register. Depends on dtad_pkg and dtad_core.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   anomaly flag, one item per frame
//  m_axis    out        m_axis_tvalid/m_axis_tready   changed, state, source, count
//  cfg       in         i_cfg_wr_en (no wait)         index i_cfg_index, data i_cfg_wdata
//
//  One item in, one item out; a new item is taken every cycle while the
//  result register is empty or being emptied. The debounce state advances
//  and the result is registered at the accept edge. A stalled output holds
//  its item and back-pressures the input side. Synchronous active-low reset
//  clears the state, the window and the registers to their defaults; no
//  clearing pass is needed.

module dual_track_alarm_debouncer
    import dtad_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [0] anomaly, [7:1] zero

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,   // [0] changed, [1] alarm_active,
                                                      // [3:2] event_source,
                                                      // [13:4] event_count, [15:14] zero

    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [RUN_CFG_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_result r_out;
    logic    r_out_valid;
    t_result core_res;
    logic    step;

    // Input taken while the result register is free or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    // Register file: writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_alarm    <= RUN_ALARM_RST;
            r_cfg.run_release  <= RUN_RELEASE_RST;
            r_cfg.window_count <= WINDOW_CNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RUN_ALARM:    r_cfg.run_alarm    <= i_cfg_wdata;
                CFG_RUN_RELEASE:  r_cfg.run_release  <= i_cfg_wdata;
                CFG_WINDOW_COUNT: r_cfg.window_count <= i_cfg_wdata[WIN_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dtad_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_anomaly (s_axis_tdata[0]),
        .i_cfg     (r_cfg),
        .o_result  (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.count, r_out.source, r_out.alarm_active,
                            r_out.changed};

endmodule

`default_nettype wire

// ===== bench/dual_track_alarm_debouncer_tb.sv =====
// Self-checking bench for dual_track_alarm_debouncer: an in-bench debounce predictor,
// directed corner items, then random phases with stalls on both stream sides.
// Depends on dtad_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module dual_track_alarm_debouncer_tb;
    import dtad_pkg::*;

    // Holds the expected verdict of every accepted frame and tracks the debounce state
    class alarm_scoreboard;
        logic [RUN_CFG_W-1:0] run_alarm_thr;
        logic [RUN_CFG_W-1:0] run_release_thr;
        logic [WIN_CFG_W-1:0] window_thr;
        bit                   in_alarm;
        logic [RUN_W-1:0]     anomaly_run;
        logic [RUN_W-1:0]     normal_run;
        bit                   window_bits [WINDOW_LEN];
        logic [WCNT_W-1:0]    window_hits;
        int                   window_head;
        t_result              verdicts [$];
        int                   mismatches;
        int                   results_seen;
        int                   raises;
        int                   releases;

        function new();
            run_alarm_thr   = RUN_ALARM_RST;
            run_release_thr = RUN_RELEASE_RST;
            window_thr      = WINDOW_CNT_RST;
            in_alarm        = 1'b0;
            anomaly_run     = '0;
            normal_run      = '0;
            clear_window();
            mismatches      = 0;
            results_seen    = 0;
            raises          = 0;
            releases        = 0;
        endfunction

        function void clear_window();
            foreach (window_bits[i]) window_bits[i] = 1'b0;
            window_hits = '0;
            window_head = 0;
        endfunction

        function void configure(t_cfg_index idx, logic [RUN_CFG_W-1:0] value);
            case (idx)
                CFG_RUN_ALARM:    run_alarm_thr   = value;
                CFG_RUN_RELEASE:  run_release_thr = value;
                CFG_WINDOW_COUNT: window_thr      = value[WIN_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // Window takes every frame, alarmed or not
        function void shift_window(bit anomaly);
            if (window_bits[window_head]) window_hits--;
            window_bits[window_head] = anomaly;
            if (anomaly) window_hits++;
            window_head = (window_head + 1) % WINDOW_LEN;
        endfunction

        // Advance the debounce state by one frame and queue its verdict
        function void note_frame(bit anomaly);
            t_result v;
            v = '0;
            if (!in_alarm) begin
                if (anomaly) begin
                    if (anomaly_run < COUNT_CAP) anomaly_run++;
                end else begin
                    anomaly_run = '0;
                end
                shift_window(anomaly);
                // run track wins when both tracks fire together
                if (anomaly_run >= run_alarm_thr) begin
                    v.source = SRC_RUN;
                    v.count  = anomaly_run;
                end else if (window_hits >= window_thr) begin
                    v.source = SRC_WINDOW;
                    v.count  = EVT_W'(window_hits);
                end
                if (v.source != SRC_NONE) begin
                    v.changed   = 1'b1;
                    in_alarm    = 1'b1;
                    anomaly_run = '0;
                    normal_run  = '0;
                    raises++;
                end
            end else begin
                if (!anomaly) begin
                    if (normal_run < COUNT_CAP) normal_run++;
                end else begin
                    normal_run = '0;
                end
                shift_window(anomaly);
                if (normal_run >= run_release_thr) begin
                    v.changed  = 1'b1;
                    v.count    = normal_run;
                    in_alarm   = 1'b0;
                    normal_run = '0;
                    clear_window();
                    releases++;
                end
            end
            v.alarm_active = in_alarm;
            verdicts.push_back(v);
        endfunction

        task report(input string what);
            mismatches++;
            $display("%0t ns MISMATCH %s", $time, what);
        endtask

        task check_result(input t_result got);
            t_result want;
            results_seen++;
            if (verdicts.size() == 0) begin
                report($sformatf("result %0d arrived with no frame outstanding", results_seen));
                return;
            end
            want = verdicts.pop_front();
            if (got.changed !== want.changed)
                report($sformatf("result %0d changed %0b, want %0b",
                                 results_seen, got.changed, want.changed));
            if (got.alarm_active !== want.alarm_active)
                report($sformatf("result %0d alarm_active %0b, want %0b",
                                 results_seen, got.alarm_active, want.alarm_active));
            if (got.source !== want.source)
                report($sformatf("result %0d event_source %0d, want %0d",
                                 results_seen, got.source, want.source));
            if (got.count !== want.count)
                report($sformatf("result %0d event_count %0d, want %0d",
                                 results_seen, got.count, want.count));
        endtask

        function int outstanding();
            return verdicts.size();
        endfunction
    endclass

    // DUT signals, all inputs known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [0] anomaly, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // [0] changed, [1] alarm_active,
                                                // [3:2] event_source, [13:4] event_count
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [RUN_CFG_W-1:0] i_cfg_wdata   = '0;

    alarm_scoreboard sb;

    // Bench controls shared between the sender, the receiver and the phase sequencer
    bit tx_idle     = 1'b0;   // sender may insert gaps
    bit rx_idle     = 1'b0;   // receiver may stall
    bit calm        = 1'b0;   // final stretch: no idling anywhere
    int hold_cycles = 0;      // one-off long receiver hold-off request
    int frames_sent = 0;
    int settings    = 0;

    dual_track_alarm_debouncer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[dual_track_alarm_debouncer] ERROR");
        $finish;
    end

    // Receiver: check each accepted result item, then pick next tready
    initial begin : result_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(t_result'(m_axis_tdata[$bits(t_result)-1:0]));
            if (hold_cycles > 0) begin
                hold_left   = hold_cycles;
                hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one frame item; tvalid stays high afterwards so back-to-back items are seamless
    task automatic send_frame(input bit anomaly);
        int gap;
        if (tx_idle && !calm && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, anomaly};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_frame(anomaly);
        frames_sent++;
    endtask

    // Called at the step of the last accept only
    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Registers change only with the block idle, after all verdicts are drained and a short pause
    task automatic set_thresholds(input int run_thr, input int rel_thr, input int win_thr);
        t_cfg_index idx [3];
        int         val [3];
        idx = '{CFG_RUN_ALARM, CFG_RUN_RELEASE, CFG_WINDOW_COUNT};
        val = '{run_thr, rel_thr, win_thr};
        wait_drained();
        repeat (3) @(posedge i_clk);
        for (int k = 0; k < 3; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_wdata <= RUN_CFG_W'(val[k]);
            @(posedge i_clk);
            sb.configure(idx[k], RUN_CFG_W'(val[k]));
        end
        i_cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // Directed frames, oldest in bit 0
    task automatic send_bits(input logic [15:0] pattern, input int n);
        for (int k = 0; k < n; k++) send_frame(pattern[k]);
        stop_sending();
    endtask

    // Random phase: bursts sized around the thresholds, mixed with noise
    task automatic run_phase(input int n_frames, input int density);
        int sent;
        int len;
        int mode;
        int thr;
        bit val;
        sent = 0;
        while (sent < n_frames) begin
            mode = $urandom_range(0, 3);
            if (mode == 0) thr = sb.run_alarm_thr;
            else if (mode == 1) thr = sb.run_release_thr;
            else thr = 18;
            len = $urandom_range(1, (thr + 2 > 120) ? 120 : thr + 2);
            for (int k = 0; k < len && sent < n_frames; k++) begin
                if (mode == 0) val = 1'b1;
                else if (mode == 1) val = 1'b0;
                else val = ($urandom_range(0, 99) < density);
                send_frame(val);
                sent++;
            end
        end
        stop_sending();
    endtask

    initial begin : stimulus
        int run_thr;
        int rel_thr;
        int win_thr;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-frame thresholds, window threshold above the window length
        set_thresholds(1, 1, 127);
        send_bits(16'b100110, 6);
        // Zero thresholds: raise and release on any frame
        set_thresholds(0, 0, 0);
        send_bits(16'b1101, 4);
        // Maximum run threshold, window of one anomaly raises
        set_thresholds(1023, 1, 1);
        send_bits(16'b010, 3);
        // Both tracks firing on one frame: run has priority
        set_thresholds(2, 1, 2);
        send_bits(16'b0101011, 7);

        // Random phases
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                run_thr = RUN_ALARM_RST;
                rel_thr = RUN_RELEASE_RST;
                win_thr = WINDOW_CNT_RST;
            end else if (p == 1) begin
                run_thr = 1023;
                rel_thr = 1023;
                win_thr = WINDOW_LEN;
            end else begin
                run_thr = $urandom_range(1, 24);
                rel_thr = $urandom_range(1, 24);
                win_thr = ($urandom_range(0, 4) == 0) ? $urandom_range(90, 127)
                                                      : $urandom_range(1, 40);
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            calm    = (p == 7);
            set_thresholds(run_thr, rel_thr, win_thr);
            if (p == 3) hold_cycles = 90;   // output backs up, input must stall
            if (p == 4) begin
                run_phase(65, $urandom_range(10, 90));
                wait_drained();             // sender pauses until all verdicts are back
                run_phase(65, $urandom_range(10, 90));
            end else begin
                run_phase(130, $urandom_range(10, 90));
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d frames under %0d threshold settings: %0d raises, %0d releases.",
                 frames_sent, settings, sb.raises, sb.releases);
        $display("%0d result items checked, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("[dual_track_alarm_debouncer] OK");
        end else begin
            $display("[dual_track_alarm_debouncer] ERROR");
        end
        $finish;
    end

endmodule
